### rtl/core/deq_pkg.sv
// deq_pkg: types and codes shared by the double-ended queue modules
// no dependencies

package deq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_PEEK       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef struct packed {
		logic [2:0]                 operation;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  front_value;
		logic signed [VALUE_W-1:0]  back_value;
		logic [COUNT_W-1:0]         count;
		logic                       is_empty;
		logic [1:0]                 status;
	} rsp_t;

	// per-item result info handed from the pointer logic to the read stage
	typedef struct packed {
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               fwd_front;
		logic               fwd_back;
	} info_t;

endpackage

### rtl/core/double_ended_queue_top.sv
// a result becomes valid once its request transfer has passed the read stage and then the output register
// throughput: one request per cycle while req_stall is low; the store has one write and two read ports,
// and the read data is held in the store's output registers
// reset (arst_n low, asynchronous): queue empty, head at zero, no result pending;
// store contents are not cleared and are never read before being written
// double_ended_queue_top: depends on deq_pkg, deq_ctrl, deq_mem

module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned IW = $clog2(DEPTH);

	logic                accept;
	logic                adv;
	logic                wr_en;
	logic [IW-1:0]       wr_addr;
	logic [IW-1:0]       rd_front_addr;
	logic [IW-1:0]       rd_back_addr;
	logic [VALUE_W-1:0]  rd_front;
	logic [VALUE_W-1:0]  rd_back;
	info_t               info;
	info_t               info_s1;
	logic                valid_s1;
	logic [VALUE_W-1:0]  wdata_s1;
	rsp_t                rsp_d;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	// read stage moves on when the output register is free or being drained
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	deq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_front_addr(rd_front_addr),
		.rd_back_addr (rd_back_addr),
		.info         (info)
	);

	deq_mem #(
		.DEPTH(DEPTH),
		.WIDTH(VALUE_W)
	) u_mem (
		.clk      (clk),
		.wr_en    (wr_en && accept),
		.wr_addr  (wr_addr),
		.wr_data  (req.value),
		.rd_en    (accept),
		.rd_addr_a(rd_front_addr),
		.rd_addr_b(rd_back_addr),
		.rd_data_a(rd_front),
		.rd_data_b(rd_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1  <= info;
			wdata_s1 <= req.value;
		end
	end

	// pushed value bypasses the store when it lands on an entry being read
	always_comb begin
		rsp_d.count    = info_s1.count;
		rsp_d.is_empty = info_s1.is_empty;
		rsp_d.status   = info_s1.status;
		if (info_s1.is_empty) begin
			rsp_d.front_value = '0;
			rsp_d.back_value  = '0;
		end else begin
			rsp_d.front_value = info_s1.fwd_front ? wdata_s1 : rd_front;
			rsp_d.back_value  = info_s1.fwd_back ? wdata_s1 : rd_back;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/deq_mem.sv
// deq_mem: element store, one write port and two registered read ports
// depends on nothing but its parameters

module deq_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned IW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [IW-1:0]    rd_addr_a,
	input  logic [IW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// reads return the old contents on a same-cycle write to the same entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

### rtl/core/deq_ctrl.sv
// deq_ctrl: head pointer and element count, store write and read addresses
// depends on deq_pkg

module deq_ctrl
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned IW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1),
	localparam int unsigned SW = CW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  req_t          req,
	output logic          wr_en,
	output logic [IW-1:0] wr_addr,
	output logic [IW-1:0] rd_front_addr,
	output logic [IW-1:0] rd_back_addr,
	output info_t         info
);

	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] head_n;
	logic [CW-1:0] count_n;
	logic [IW-1:0] head_dec;
	logic [IW-1:0] head_inc;
	logic [SW-1:0] tail_sum;
	logic [IW-1:0] tail_addr;
	logic [SW-1:0] back_sum;
	logic [IW-1:0] back_addr;
	logic          full;
	logic          empty;
	logic [1:0]    status;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

	// sums stay below twice the depth, so one subtract wraps them
	assign tail_sum  = SW'(head_q) + SW'(count_q);
	assign tail_addr = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);

	always_comb begin
		head_n  = head_q;
		count_n = count_q;
		status  = ST_OK;
		wr_en   = 1'b0;
		wr_addr = tail_addr;
		unique case (req.operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_OVERFLOW;
				end else begin
					head_n  = head_dec;
					count_n = count_q + 1'b1;
					wr_en   = 1'b1;
					wr_addr = head_dec;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status = ST_OVERFLOW;
				end else begin
					count_n = count_q + 1'b1;
					wr_en   = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = ST_UNDERFLOW;
				end else begin
					head_n  = head_inc;
					count_n = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = ST_UNDERFLOW;
				end else begin
					count_n = count_q - 1'b1;
				end
			end
			OP_CLEAR: begin
				head_n  = '0;
				count_n = '0;
			end
			default: begin
				// peek and unused codes leave the queue alone
			end
		endcase
	end

	// back entry after the update; meaningless when the queue ends up empty
	assign back_sum  = SW'(head_n) + SW'(count_n) - 1'b1;
	assign back_addr = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);

	assign rd_front_addr  = head_n;
	assign rd_back_addr   = back_addr;
	assign info.status    = status;
	assign info.count     = COUNT_W'(count_n);
	assign info.is_empty  = (count_n == '0);
	assign info.fwd_front = wr_en && (wr_addr == head_n);
	assign info.fwd_back  = wr_en && (wr_addr == back_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			count_q <= count_n;
		end
	end

endmodule

### rtl/core/deq_chk.sv
// deq_chk: port-level checks on the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_top

module deq_chk
	import deq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// an empty queue reports zero values and zero count
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |->
			rsp.count == '0 && rsp.front_value == '0 && rsp.back_value == '0)
		else $error("empty result carries data");

	// underflow only happens on an empty queue, which stays empty
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_UNDERFLOW |-> rsp.is_empty)
		else $error("underflow on a non-empty queue");

	// overflow only happens on a full queue, so its result is never empty
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_OVERFLOW |-> !rsp.is_empty)
		else $error("overflow on an empty queue");

	// a new result needs a request transfer that has passed the read stage and the output register
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("result without a request");

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (.*);
